>>> design/aef_pkg.sv
// aef_pkg: shared types, widths and constants for the azimuth/elevation unit
// no dependencies; every design file refers to it by scoped names
package aef_pkg;

  // field widths of the transaction payloads
  localparam int COORD_WIDTH = 32;
  localparam int ANGLE_WIDTH = 16;

  // front end: difference, magnitude, normalisation
  localparam int DIFF_W   = COORD_WIDTH + 1;
  localparam int MAG_W    = COORD_WIDTH;
  localparam int SHAMT_W  = $clog2(MAG_W);
  localparam int NORM_TOP = 30;
  localparam int NORM_W   = NORM_TOP + 1;
  localparam int SQ_W     = 2 * NORM_W;

  // square root chain: one result bit per cell
  localparam int SQRT_W     = 64;
  localparam int SQRT_TOP   = 62;
  localparam int SQRT_STEPS = 32;
  localparam int ROOT_W     = 32;

  // vectoring rotation chain
  localparam int CORDIC_STEPS = 31;
  localparam int CX_W         = 35;
  localparam int ATAN_W       = 32;
  localparam int Z_W          = ATAN_W + 1;

  localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(64'd1 << 30);

  // rounding of a 2^-32 turn angle to angle units, halves upward
  localparam int ROUND_SH = 32 - ANGLE_WIDTH;
  localparam logic [Z_W:0] ROUND_ADD = (Z_W + 1)'(1) << ROUND_SH;
  localparam logic [ANGLE_WIDTH-1:0] HALF_TURN = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1);

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001
  };

  // input transaction: observer and target points
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] from_x;
    logic signed [COORD_WIDTH-1:0] from_y;
    logic signed [COORD_WIDTH-1:0] from_z;
    logic signed [COORD_WIDTH-1:0] to_x;
    logic signed [COORD_WIDTH-1:0] to_y;
    logic signed [COORD_WIDTH-1:0] to_z;
  } item_t;

  // output transaction
  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] azimuth;
    logic signed [ANGLE_WIDTH-1:0] elevation;
    logic                          degenerate;
  } result_t;

  // normalised magnitudes and signs carried alongside the root
  typedef struct packed {
    logic [NORM_W-1:0] mx;
    logic [NORM_W-1:0] my;
    logic [NORM_W-1:0] mz;
    logic              neg_dx;
    logic              neg_dy;
    logic              neg_dz;
    logic              degen;
  } side_t;

  // square root partial state
  typedef struct packed {
    logic [SQRT_W-1:0] rem;
    logic [SQRT_W-1:0] root;
  } sqrt_t;

  // one vectoring lane: atan(y/x) with zero flags of the operands
  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   a_zero;
    logic                   b_zero;
  } lane_t;

  // placement flags
  typedef struct packed {
    logic neg_dx;
    logic neg_dy;
    logic neg_dz;
    logic degen;
  } flags_t;

  // both lanes of a rotation cell
  typedef struct packed {
    lane_t  az;
    lane_t  el;
    flags_t flags;
  } cordic_t;

endpackage

>>> design/azimuth_elevation_from_points_unit.sv
// Azimuth and elevation of the line between two points, fully pipelined.
// Stages from an accepted transaction to result_valid: 6 front stages, 32 square root
// cells, 31 rotation cells, rounding stage, output register. Throughput: one transaction
// per cycle while item_stall is low; the row of cells advances as a whole and
// keeps moving while the output register holds a stalled result and its last stage is empty.
// Reset (rst, synchronous) clears all valid flags; payload registers are not reset.
module azimuth_elevation_from_points_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  aef_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output aef_pkg::result_t result
);

  logic en;
  logic out_load;

  // root chain
  logic             sq_valid [aef_pkg::SQRT_STEPS+1];
  aef_pkg::sqrt_t   sq       [aef_pkg::SQRT_STEPS+1];
  aef_pkg::side_t   side     [aef_pkg::SQRT_STEPS+1];

  // rotation chain
  logic             cor_valid [aef_pkg::CORDIC_STEPS+1];
  aef_pkg::cordic_t cor       [aef_pkg::CORDIC_STEPS+1];

  logic [aef_pkg::ROOT_W-1:0] root;

  // rounding stage
  logic                            rnd_valid;
  logic [aef_pkg::ANGLE_WIDTH-1:0] rnd_az;
  logic [aef_pkg::ANGLE_WIDTH-1:0] rnd_el;
  logic                            rnd_az_none;
  aef_pkg::flags_t                 rnd_flags;

  logic [aef_pkg::ANGLE_WIDTH-1:0] az_val;
  logic [aef_pkg::ANGLE_WIDTH-1:0] el_val;
  aef_pkg::result_t                result_next;

  // flow control: the row moves unless its last stage would overrun a held result
  assign out_load   = !result_valid || !result_stall;
  assign en         = out_load || !rnd_valid;
  assign item_stall = !en;

  aef_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .item_valid (item_valid),
    .item       (item),
    .sq_valid   (sq_valid[0]),
    .sq         (sq[0]),
    .side       (side[0])
  );

  for (genvar k = 0; k < aef_pkg::SQRT_STEPS; k++) begin : g_sqrt
    aef_sqrt_cell #(
      .STEP (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .feed_valid (sq_valid[k]),
      .feed       (sq[k]),
      .feed_side  (side[k]),
      .pass_valid (sq_valid[k+1]),
      .pass       (sq[k+1]),
      .pass_side  (side[k+1])
    );
  end

  // load both lanes: azimuth from (mx, my), elevation from (root, mz)
  assign root = sq[aef_pkg::SQRT_STEPS].root[aef_pkg::ROOT_W-1:0];
  always_comb begin
    cor_valid[0]         = sq_valid[aef_pkg::SQRT_STEPS];
    cor[0].az.x          = aef_pkg::CX_W'(side[aef_pkg::SQRT_STEPS].mx);
    cor[0].az.y          = aef_pkg::CX_W'(side[aef_pkg::SQRT_STEPS].my);
    cor[0].az.z          = '0;
    cor[0].az.a_zero     = (side[aef_pkg::SQRT_STEPS].mx == '0);
    cor[0].az.b_zero     = (side[aef_pkg::SQRT_STEPS].my == '0);
    cor[0].el.x          = aef_pkg::CX_W'(root);
    cor[0].el.y          = aef_pkg::CX_W'(side[aef_pkg::SQRT_STEPS].mz);
    cor[0].el.z          = '0;
    cor[0].el.a_zero     = (root == '0);
    cor[0].el.b_zero     = (side[aef_pkg::SQRT_STEPS].mz == '0);
    cor[0].flags.neg_dx  = side[aef_pkg::SQRT_STEPS].neg_dx;
    cor[0].flags.neg_dy  = side[aef_pkg::SQRT_STEPS].neg_dy;
    cor[0].flags.neg_dz  = side[aef_pkg::SQRT_STEPS].neg_dz;
    cor[0].flags.degen   = side[aef_pkg::SQRT_STEPS].degen;
  end

  for (genvar k = 0; k < aef_pkg::CORDIC_STEPS; k++) begin : g_cordic
    aef_cordic_cell #(
      .STEP (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .feed_valid (cor_valid[k]),
      .feed       (cor[k]),
      .pass_valid (cor_valid[k+1]),
      .pass       (cor[k+1])
    );
  end

  // quadrant angle: zero operands, clamp to zero and a quarter turn, round to angle units
  function automatic logic [aef_pkg::ANGLE_WIDTH-1:0] quad_units(input aef_pkg::lane_t l);
    logic signed [aef_pkg::Z_W-1:0] q;
    logic [aef_pkg::Z_W:0]          t;
    priority if (l.b_zero) begin
      q = '0;
    end else if (l.a_zero) begin
      q = aef_pkg::QUARTER_TURN;
    end else if (l.z < 0) begin
      q = '0;
    end else if (l.z > aef_pkg::QUARTER_TURN) begin
      q = aef_pkg::QUARTER_TURN;
    end else begin
      q = l.z;
    end
    t = {q, 1'b0} + aef_pkg::ROUND_ADD;
    return aef_pkg::ANGLE_WIDTH'(t >> (aef_pkg::ROUND_SH + 1));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_valid <= 1'b0;
    end else if (en) begin
      rnd_valid <= cor_valid[aef_pkg::CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd_az      <= quad_units(cor[aef_pkg::CORDIC_STEPS].az);
      rnd_el      <= quad_units(cor[aef_pkg::CORDIC_STEPS].el);
      rnd_az_none <= cor[aef_pkg::CORDIC_STEPS].az.a_zero
                     && cor[aef_pkg::CORDIC_STEPS].az.b_zero;
      rnd_flags   <= cor[aef_pkg::CORDIC_STEPS].flags;
    end
  end

  // place the quadrant angles by the signs of the differences
  always_comb begin
    priority if (rnd_flags.degen || rnd_az_none) begin
      az_val = '0;
    end else if (!rnd_flags.neg_dx && !rnd_flags.neg_dy) begin
      az_val = rnd_az;
    end else if (!rnd_flags.neg_dx) begin
      az_val = -rnd_az;
    end else if (!rnd_flags.neg_dy) begin
      az_val = aef_pkg::HALF_TURN - rnd_az;
    end else begin
      az_val = rnd_az - aef_pkg::HALF_TURN;
    end
    priority if (rnd_flags.degen) begin
      el_val = '0;
    end else if (rnd_flags.neg_dz) begin
      el_val = -rnd_el;
    end else begin
      el_val = rnd_el;
    end
  end

  assign result_next.azimuth    = az_val;
  assign result_next.elevation  = el_val;
  assign result_next.degenerate = rnd_flags.degen;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= rnd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= result_next;
    end
  end

endmodule

>>> design/aef_front.sv
// aef_front: difference, magnitude, normalisation and squares ahead of the root chain
// depends on aef_pkg
module aef_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           item_valid,
  input  aef_pkg::item_t item,
  output logic           sq_valid,
  output aef_pkg::sqrt_t sq,
  output aef_pkg::side_t side
);

  // stage a: differences
  logic                               a_valid;
  logic signed [aef_pkg::DIFF_W-1:0] a_dx, a_dy, a_dz;

  // stage b: magnitudes and signs
  logic                             b_valid;
  logic [aef_pkg::MAG_W-1:0]        b_mx, b_my, b_mz;
  logic                             b_nx, b_ny, b_nz;

  // stage c: leading one of the largest magnitude
  logic                             c_valid;
  logic [aef_pkg::MAG_W-1:0]        c_mx, c_my, c_mz;
  logic                             c_nx, c_ny, c_nz, c_degen;
  logic [aef_pkg::SHAMT_W-1:0]      c_p;

  // stage d: normalised magnitudes
  logic                             d_valid;
  logic [aef_pkg::NORM_W-1:0]       d_mx, d_my, d_mz;
  logic                             d_nx, d_ny, d_nz, d_degen;

  // stage e: squares
  logic                             e_valid;
  logic [aef_pkg::SQ_W-1:0]         e_sqx, e_sqy;
  aef_pkg::side_t                   e_side;

  // stage f: sum of squares
  logic                             f_valid;
  logic [aef_pkg::SQRT_W-1:0]       f_rem;
  aef_pkg::side_t                   f_side;

  logic [aef_pkg::MAG_W-1:0]        mag_or;
  logic [aef_pkg::SHAMT_W-1:0]      lead;
  logic [aef_pkg::SQ_W-1:0]         sqx_prod, sqy_prod;

  function automatic logic [aef_pkg::MAG_W-1:0] mag_of(
    input logic signed [aef_pkg::DIFF_W-1:0] d
  );
    logic signed [aef_pkg::DIFF_W-1:0] n;
    n = d[aef_pkg::DIFF_W-1] ? -d : d;
    return n[aef_pkg::MAG_W-1:0];
  endfunction

  // scale so the leading one of the largest magnitude lands on the top bit
  function automatic logic [aef_pkg::NORM_W-1:0] norm_of(
    input logic [aef_pkg::MAG_W-1:0]   m,
    input logic [aef_pkg::SHAMT_W-1:0] p
  );
    logic [aef_pkg::MAG_W+aef_pkg::NORM_TOP-1:0] ext;
    logic [aef_pkg::MAG_W+aef_pkg::NORM_TOP-1:0] sh;
    ext = {m, {aef_pkg::NORM_TOP{1'b0}}};
    sh  = ext >> p;
    return sh[aef_pkg::NORM_W-1:0];
  endfunction

  // leading one of the or of all magnitudes equals that of the largest
  assign mag_or = b_mx | b_my | b_mz;
  always_comb begin
    lead = '0;
    for (int i = 0; i < aef_pkg::MAG_W; i++) begin
      if (mag_or[i]) begin
        lead = aef_pkg::SHAMT_W'(i);
      end
    end
  end

  assign sqx_prod = aef_pkg::SQ_W'(d_mx) * aef_pkg::SQ_W'(d_mx);
  assign sqy_prod = aef_pkg::SQ_W'(d_my) * aef_pkg::SQ_W'(d_my);

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
    end else if (en) begin
      a_valid <= item_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
      f_valid <= e_valid;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      a_dx <= aef_pkg::DIFF_W'(item.to_x) - aef_pkg::DIFF_W'(item.from_x);
      a_dy <= aef_pkg::DIFF_W'(item.to_y) - aef_pkg::DIFF_W'(item.from_y);
      a_dz <= aef_pkg::DIFF_W'(item.to_z) - aef_pkg::DIFF_W'(item.from_z);

      b_mx <= mag_of(a_dx);
      b_my <= mag_of(a_dy);
      b_mz <= mag_of(a_dz);
      b_nx <= a_dx[aef_pkg::DIFF_W-1];
      b_ny <= a_dy[aef_pkg::DIFF_W-1];
      b_nz <= a_dz[aef_pkg::DIFF_W-1];

      c_mx    <= b_mx;
      c_my    <= b_my;
      c_mz    <= b_mz;
      c_nx    <= b_nx;
      c_ny    <= b_ny;
      c_nz    <= b_nz;
      c_degen <= (mag_or == '0);
      c_p     <= lead;

      d_mx    <= norm_of(c_mx, c_p);
      d_my    <= norm_of(c_my, c_p);
      d_mz    <= norm_of(c_mz, c_p);
      d_nx    <= c_nx;
      d_ny    <= c_ny;
      d_nz    <= c_nz;
      d_degen <= c_degen;

      e_sqx         <= sqx_prod;
      e_sqy         <= sqy_prod;
      e_side.mx     <= d_mx;
      e_side.my     <= d_my;
      e_side.mz     <= d_mz;
      e_side.neg_dx <= d_nx;
      e_side.neg_dy <= d_ny;
      e_side.neg_dz <= d_nz;
      e_side.degen  <= d_degen;

      f_rem  <= aef_pkg::SQRT_W'(e_sqx) + aef_pkg::SQRT_W'(e_sqy);
      f_side <= e_side;
    end
  end

  assign sq_valid = f_valid;
  assign sq.rem   = f_rem;
  assign sq.root  = '0;
  assign side     = f_side;

endmodule

>>> design/aef_sqrt_cell.sv
// aef_sqrt_cell: one step of the restoring integer square root, one root bit per cell
// depends on aef_pkg
module aef_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           feed_valid,
  input  aef_pkg::sqrt_t feed,
  input  aef_pkg::side_t feed_side,
  output logic           pass_valid,
  output aef_pkg::sqrt_t pass,
  output aef_pkg::side_t pass_side
);

  localparam logic [aef_pkg::SQRT_W-1:0] BIT_VAL =
    aef_pkg::SQRT_W'(1) << (aef_pkg::SQRT_TOP - 2 * STEP);

  logic [aef_pkg::SQRT_W-1:0] trial;
  aef_pkg::sqrt_t             step_next;

  // trial subtract of the candidate bit
  assign trial = feed.root + BIT_VAL;
  always_comb begin
    if (feed.rem >= trial) begin
      step_next.rem  = feed.rem - trial;
      step_next.root = (feed.root >> 1) + BIT_VAL;
    end else begin
      step_next.rem  = feed.rem;
      step_next.root = feed.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_valid <= 1'b0;
    end else if (en) begin
      pass_valid <= feed_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pass      <= step_next;
      pass_side <= feed_side;
    end
  end

endmodule

>>> design/aef_cordic_cell.sv
// aef_cordic_cell: one vectoring rotation step for the azimuth and elevation lanes
// depends on aef_pkg
module aef_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             feed_valid,
  input  aef_pkg::cordic_t feed,
  output logic             pass_valid,
  output aef_pkg::cordic_t pass
);

  localparam logic signed [aef_pkg::Z_W-1:0] ANGLE =
    aef_pkg::Z_W'({1'b0, aef_pkg::ATAN_TAB[STEP]});

  aef_pkg::cordic_t rot_next;

  // rotate toward y = 0 and book the step angle
  function automatic aef_pkg::lane_t rotate(input aef_pkg::lane_t l);
    aef_pkg::lane_t         r;
    logic signed [aef_pkg::CX_W-1:0] sx;
    logic signed [aef_pkg::CX_W-1:0] sy;
    r  = l;
    sy = l.y >>> STEP;
    sx = l.x >>> STEP;
    if (l.y > 0) begin
      r.x = l.x + sy;
      r.y = l.y - sx;
      r.z = l.z + ANGLE;
    end else begin
      r.x = l.x - sy;
      r.y = l.y + sx;
      r.z = l.z - ANGLE;
    end
    return r;
  endfunction

  assign rot_next.az    = rotate(feed.az);
  assign rot_next.el    = rotate(feed.el);
  assign rot_next.flags = feed.flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_valid <= 1'b0;
    end else if (en) begin
      pass_valid <= feed_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pass <= rot_next;
    end
  end

endmodule

>>> test/azimuth_elevation_from_points_unit_test.sv
// self-checking bench for azimuth_elevation_from_points_unit: random idling on both sides,
// a bit-exact angle predictor and an in-order result check
// depends on aef_pkg and the unit itself
module azimuth_elevation_from_points_unit_test;

  localparam int CW = aef_pkg::COORD_WIDTH;
  localparam int AW = aef_pkg::ANGLE_WIDTH;
  localparam int ROUND_SH = 32 - AW;
  localparam int ROTATIONS = 31;
  localparam longint QUARTER = 64'sd1 << 30;
  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 100;

  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};

  // atan(2^-i) in units of 2^-32 turn
  localparam longint ATAN_POW2 [ROTATIONS] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
    'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
    'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
    'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
    'h00000001
  };

  typedef enum int {SHAPE_ANY, SHAPE_NEAR, SHAPE_AXIS, SHAPE_SAME, SHAPE_BOUNDARY} pair_shape_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  aef_pkg::item_t   item;
  logic             result_valid;
  logic             result_stall = 1'b0;
  aef_pkg::result_t result;

  aef_pkg::result_t expected_angles [$];
  int      fail_count = 0;
  int      quiet_cycles = 0;
  bit      tx_idling = 1'b1;
  bit      rx_idling = 1'b1;
  bit      long_hold_req = 1'b0;
  int      rx_gap_left = 0;
  int      rx_hold_left = 0;

  azimuth_elevation_from_points_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #5 clk = ~clk;

  // integer square root, one result bit per pass
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root, probe;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // vectoring rotations: atan(b/a) in 2^-32 turn, clamped to zero and a quarter turn
  function automatic longint quadrant_angle(input longint unsigned a, input longint unsigned b);
    longint x, y, z, sx, sy;
    int i;
    if (b == 0) return 0;
    if (a == 0) return QUARTER;
    x = a;
    y = b;
    z = 0;
    for (i = 0; i < ROTATIONS; i++) begin
      sy = y >>> i;
      sx = x >>> i;
      if (y > 0) begin
        x = x + sy;
        y = y - sx;
        z = z + ATAN_POW2[i];
      end else begin
        x = x - sy;
        y = y + sx;
        z = z - ATAN_POW2[i];
      end
    end
    if (z < 0) z = 0;
    if (z > QUARTER) z = QUARTER;
    return z;
  endfunction

  // 2^-32 turn to angle units, halves upward
  function automatic longint round_to_units(input longint z);
    return (z + (64'sd1 << (ROUND_SH - 1))) >>> ROUND_SH;
  endfunction

  // expected angles of the line of sight from one point to the other
  function automatic aef_pkg::result_t predict_angles(input aef_pkg::item_t p);
    longint dx, dy, dz, a, az, el, half;
    longint unsigned mx, my, mz, peak;
    aef_pkg::result_t r;
    dx = longint'(p.to_x) - longint'(p.from_x);
    dy = longint'(p.to_y) - longint'(p.from_y);
    dz = longint'(p.to_z) - longint'(p.from_z);
    mx = (dx < 0) ? -dx : dx;
    my = (dy < 0) ? -dy : dy;
    mz = (dz < 0) ? -dz : dz;
    half = 64'sd1 << (AW - 1);
    r = '0;
    peak = mx;
    if (my > peak) peak = my;
    if (mz > peak) peak = mz;
    if (peak == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    // common scaling so the largest magnitude lies in [2^30, 2^31)
    while (peak >= (64'd1 << 31)) begin
      peak = peak >> 1; mx = mx >> 1; my = my >> 1; mz = mz >> 1;
    end
    while (peak < (64'd1 << 30)) begin
      peak = peak << 1; mx = mx << 1; my = my << 1; mz = mz << 1;
    end
    if (mx == 0 && my == 0) begin
      az = 0;
    end else begin
      a = round_to_units(quadrant_angle(mx, my));
      if (dx >= 0) az = (dy >= 0) ? a : -a;
      else         az = (dy >= 0) ? (half - a) : -(half - a);
    end
    a = round_to_units(quadrant_angle(int_sqrt(mx * mx + my * my), mz));
    el = (dz < 0) ? -a : a;
    r.azimuth = az[AW-1:0];
    r.elevation = el[AW-1:0];
    return r;
  endfunction

  function automatic aef_pkg::item_t points(
    input logic signed [CW-1:0] fx, fy, fz, tx, ty, tz
  );
    aef_pkg::item_t p;
    p.from_x = fx; p.from_y = fy; p.from_z = fz;
    p.to_x = tx; p.to_y = ty; p.to_z = tz;
    return p;
  endfunction

  function automatic logic signed [CW-1:0] boundary_coord();
    case ($urandom_range(0, 5))
      0: return C_MIN;
      1: return C_MAX;
      2: return '0;
      3: return '1;
      4: return 1;
      default: return $urandom;
    endcase
  endfunction

  // offset spread over every order of magnitude
  function automatic logic signed [CW-1:0] random_offset();
    logic signed [CW-1:0] d;
    d = $urandom;
    return d >>> $urandom_range(0, CW - 1);
  endfunction

  function automatic aef_pkg::item_t random_pair();
    aef_pkg::item_t p;
    pair_shape_t shape;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 6)       shape = SHAPE_ANY;
    else if (pick < 13) shape = SHAPE_NEAR;
    else if (pick < 16) shape = SHAPE_AXIS;
    else if (pick < 17) shape = SHAPE_SAME;
    else                shape = SHAPE_BOUNDARY;
    p = points($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    case (shape)
      SHAPE_NEAR: begin
        p.to_x = p.from_x + random_offset();
        p.to_y = p.from_y + random_offset();
        p.to_z = p.from_z + random_offset();
      end
      SHAPE_AXIS: begin
        p.to_x = p.from_x; p.to_y = p.from_y; p.to_z = p.from_z;
        if ($urandom_range(0, 1)) p.to_x = p.from_x + random_offset();
        if ($urandom_range(0, 1)) p.to_y = p.from_y + random_offset();
        if ($urandom_range(0, 1)) p.to_z = p.from_z + random_offset();
      end
      SHAPE_SAME: begin
        p.to_x = p.from_x; p.to_y = p.from_y; p.to_z = p.from_z;
      end
      SHAPE_BOUNDARY: begin
        p = points(boundary_coord(), boundary_coord(), boundary_coord(),
                   boundary_coord(), boundary_coord(), boundary_coord());
      end
      default: ;
    endcase
    return p;
  endfunction

  // offer one transaction, possibly after an idle burst, and wait for acceptance
  task automatic send_points(input aef_pkg::item_t p);
    int gap;
    gap = 0;
    if (tx_idling && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 19);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= p;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    expected_angles.push_back(predict_angles(p));
  endtask

  // field extremes, both directions along every axis
  task automatic test_extremes();
    send_points(points(0, 0, 0, 0, 0, 0));
    send_points(points(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
    send_points(points(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
    send_points(points(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN));
    send_points(points(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN));
    send_points(points(C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
    send_points(points(C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN));
    send_points(points(C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN));
    send_points(points(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX));
    send_points(points('1, '1, '1, 0, 0, 0));
    send_points(points(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
  endtask

  // coinciding points, vertical lines, half turn and the principal diagonals
  task automatic test_special_cases();
    send_points(points(C_MAX, C_MIN, 12345, C_MAX, C_MIN, 12345));
    send_points(points(7, -9, 0, 7, -9, 1));
    send_points(points(0, 0, C_MAX, 0, 0, C_MIN));
    send_points(points(0, 0, 0, -1, 0, 0));
    send_points(points(0, 0, 0, 1, 0, 0));
    send_points(points(0, 0, 0, 0, 1, 0));
    send_points(points(0, 0, 0, 0, -1, 0));
    send_points(points(0, 0, 0, 1, 1, 0));
    send_points(points(0, 0, 0, -1, -1, 0));
    send_points(points(0, 0, 0, 1, -1, 0));
    send_points(points(0, 0, 0, 1, 0, 1));
    send_points(points(5, 5, 5, 8, -2, 7));
  endtask

  // random pairs in chunks, idling on or off per chunk
  task automatic test_random_pairs();
    int chunk;
    int n;
    for (chunk = 0; chunk < 12; chunk++) begin
      tx_idling = ($urandom_range(0, 3) != 0);
      rx_idling = ($urandom_range(0, 3) != 0);
      for (n = 0; n < 50; n++) send_points(random_pair());
    end
    tx_idling = 1'b1;
    rx_idling = 1'b1;
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    int n;
    tx_idling = 1'b0;
    long_hold_req = 1'b1;
    for (n = 0; n < 200; n++) send_points(random_pair());
    tx_idling = 1'b1;
  endtask

  // closing stretch with no idling on either side
  task automatic test_streaming();
    int n;
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    for (n = 0; n < 80; n++) send_points(random_pair());
  endtask

  // receiver stall: long hold on request, otherwise random bursts
  always @(posedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      rx_hold_left = LONG_HOLD;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      result_stall <= 1'b1;
    end else if (rx_gap_left > 0) begin
      rx_gap_left = rx_gap_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      if (rx_idling && $urandom_range(0, 5) == 0) rx_gap_left = $urandom_range(1, 19);
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    aef_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_angles.size() == 0) begin
        $error("result with no prediction outstanding: az %0d el %0d degenerate %0b",
               result.azimuth, result.elevation, result.degenerate);
        fail_count++;
      end else begin
        want = expected_angles.pop_front();
        if (result.azimuth !== want.azimuth) begin
          $error("azimuth: expected %0d, got %0d", want.azimuth, result.azimuth);
          fail_count++;
        end
        if (result.elevation !== want.elevation) begin
          $error("elevation: expected %0d, got %0d", want.elevation, result.elevation);
          fail_count++;
        end
        if (result.degenerate !== want.degenerate) begin
          $error("degenerate: expected %0b, got %0b", want.degenerate, result.degenerate);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_special_cases();
    test_random_pairs();
    test_backpressure();
    test_streaming();
    item_valid <= 1'b0;
    // drain, then allow for anything unexpected still in the pipeline
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
